>>> rtl/core/pnf_pkg.sv
// Shared types and constants of the post-Newtonian frequency block.
`default_nettype none
package pnf_pkg;

  localparam int unsigned TD_W   = 48;
  localparam int unsigned FREQ_W = 52;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_PN_ORDER      = 3'd0;
  localparam logic [IDX_W-1:0] CFG_COEF_A2       = 3'd1;
  localparam logic [IDX_W-1:0] CFG_COEF_A3       = 3'd2;
  localparam logic [IDX_W-1:0] CFG_COEF_A4       = 3'd3;
  localparam logic [IDX_W-1:0] CFG_EIGHT_PI_MASS = 3'd4;

  // Reset values
  localparam logic [2:0]       ORDER_RESET = 3'd4;
  localparam logic [CFG_W-1:0] MASS_RESET  = 32'h0100_0000;

  // Saturated frequency
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  // Per-request classification made at the front
  typedef struct packed {
    logic bad;
    logic use_a2;
    logic use_a3;
    logic use_a4;
  } flags_t;

  typedef struct packed {
    logic [TD_W-1:0] td;
    flags_t          flags;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] a2;
    logic [CFG_W-1:0] a3;
    logic [CFG_W-1:0] a4;
    logic [CFG_W-1:0] mass;
  } coef_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              bad;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/pnf_fifo.sv
// Small register-based queue.
`default_nettype none
module pnf_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         full,
  output logic         empty,
  output logic [W-1:0] rdata
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!do_push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store request payload
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule
`default_nettype wire

>>> rtl/core/pnf_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
`default_nettype none
module pnf_isqrt #(
  parameter int unsigned SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [63:0]     in_rad,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [31:0]     out_root,
  output logic [SB_W-1:0] out_sb
);

  localparam int unsigned STEPS = 32;

  logic            valid_r [STEPS];
  logic [63:0]     rad_r   [STEPS];
  logic [32:0]     rem_r   [STEPS];
  logic [31:0]     root_r  [STEPS];
  logic [SB_W-1:0] sb_r    [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic            v_i;
    logic [63:0]     rad_i;
    logic [32:0]     rem_i;
    logic [31:0]     root_i;
    logic [SB_W-1:0] sb_i;
    logic [34:0]     sh;
    logic [34:0]     trial;
    logic            take;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign sb_i   = in_sb;
    end else begin : g_next
      assign v_i    = valid_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign sb_i   = sb_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign sh    = {rem_i, rad_i[63:62]};
    assign trial = {1'b0, root_i, 2'b01};
    assign take  = (sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_i[61:0], 2'b00};
        rem_r[k]  <= take ? 33'(sh - trial) : sh[32:0];
        root_r[k] <= {root_i[30:0], take};
        sb_r[k]   <= sb_i;
      end
    end
  end

  assign out_valid = valid_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_sb    = sb_r[STEPS-1];

endmodule
`default_nettype wire

>>> rtl/core/pnf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module pnf_div #(
  parameter int unsigned QW   = 35,
  parameter int unsigned DW   = 32,
  parameter int unsigned SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [DW-1:0]   in_rem,   // upper numerator part, below in_den
  input  logic [QW-1:0]   in_low,   // numerator bits still to bring down
  input  logic [DW-1:0]   in_den,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [QW-1:0]   out_quo,
  output logic [SB_W-1:0] out_sb
);

  logic            valid_r [QW];
  logic [DW-1:0]   rem_r   [QW];
  logic [QW-1:0]   lq_r    [QW];  // numerator bits shift out, quotient bits shift in
  logic [DW-1:0]   den_r   [QW];
  logic [SB_W-1:0] sb_r    [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic            v_i;
    logic [DW-1:0]   rem_i;
    logic [QW-1:0]   lq_i;
    logic [DW-1:0]   den_i;
    logic [SB_W-1:0] sb_i;
    logic [DW:0]     x;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = in_rem;
      assign lq_i  = in_low;
      assign den_i = in_den;
      assign sb_i  = in_sb;
    end else begin : g_next
      assign v_i   = valid_r[k-1];
      assign rem_i = rem_r[k-1];
      assign lq_i  = lq_r[k-1];
      assign den_i = den_r[k-1];
      assign sb_i  = sb_r[k-1];
    end

    // Bring down one bit and subtract where it fits
    assign x  = {rem_i, lq_i[QW-1]};
    assign ge = (x >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(x - {1'b0, den_i}) : x[DW-1:0];
        lq_r[k]  <= {lq_i[QW-2:0], ge};
        den_r[k] <= den_i;
        sb_r[k]  <= sb_i;
      end
    end
  end

  assign out_valid = valid_r[QW-1];
  assign out_quo   = lq_r[QW-1];
  assign out_sb    = sb_r[QW-1];

endmodule
`default_nettype wire

>>> rtl/core/pnf_mul.sv
// Two-stage unsigned multiplier split into half-width partial products, then shifted.
`default_nettype none
module pnf_mul #(
  parameter int unsigned AW   = 34,
  parameter int unsigned BW   = 34,
  parameter int unsigned OW   = 36,
  parameter int unsigned SH   = 32,
  parameter int unsigned SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [AW-1:0]   in_a,
  input  logic [BW-1:0]   in_b,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [OW-1:0]   out_p,
  output logic [SB_W-1:0] out_sb
);

  localparam int unsigned AL = (AW + 1) / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = (BW + 1) / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;

  logic [AL+BL-1:0] pll_r;
  logic [AL+BH-1:0] plh_r;
  logic [AH+BL-1:0] phl_r;
  logic [AH+BH-1:0] phh_r;
  logic [SB_W-1:0]  sb1_r;
  logic             v1_r;
  logic [PW-1:0]    full_p;
  logic             v2_r;
  logic [OW-1:0]    p_r;
  logic [SB_W-1:0]  sb2_r;

  // Combine partial products
  assign full_p = PW'(pll_r) + (PW'(plh_r) << BL) + (PW'(phl_r) << AL)
                + (PW'(phh_r) << (AL + BL));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= in_a[AL-1:0]  * in_b[BL-1:0];
      plh_r <= in_a[AL-1:0]  * in_b[BW-1:BL];
      phl_r <= in_a[AW-1:AL] * in_b[BL-1:0];
      phh_r <= in_a[AW-1:AL] * in_b[BW-1:BL];
      sb1_r <= in_sb;
      p_r   <= OW'(full_p >> SH);
      sb2_r <= sb1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_p     = p_r;
  assign out_sb    = sb2_r;

endmodule
`default_nettype wire

>>> rtl/core/pnf_front.sv
// Front end: configuration registers, request classification and the issue queue.
`default_nettype none
module pnf_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [pnf_pkg::TD_W-1:0]  td,
  input  logic                      cfg_we,
  input  logic [pnf_pkg::IDX_W-1:0] cfg_index,
  input  logic [pnf_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      q_pop,
  output logic                      q_empty,
  output pnf_pkg::item_t            q_item,
  output pnf_pkg::coef_t            cfg
);

  logic [2:0]     order_r;
  pnf_pkg::coef_t coef_r;
  pnf_pkg::item_t item_nxt;
  logic [$bits(pnf_pkg::item_t)-1:0] q_rdata;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= pnf_pkg::ORDER_RESET;
      coef_r.a2   <= '0;
      coef_r.a3   <= '0;
      coef_r.a4   <= '0;
      coef_r.mass <= pnf_pkg::MASS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pnf_pkg::CFG_PN_ORDER:      order_r     <= cfg_wdata[2:0];
        pnf_pkg::CFG_COEF_A2:       coef_r.a2   <= cfg_wdata;
        pnf_pkg::CFG_COEF_A3:       coef_r.a3   <= cfg_wdata;
        pnf_pkg::CFG_COEF_A4:       coef_r.a4   <= cfg_wdata;
        pnf_pkg::CFG_EIGHT_PI_MASS: coef_r.mass <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = coef_r;

  // Classify the request; orders above four act as four
  always_comb begin
    item_nxt.td           = td;
    item_nxt.flags.bad    = (td == '0);
    item_nxt.flags.use_a2 = (order_r >= 3'd2);
    item_nxt.flags.use_a3 = (order_r >= 3'd3);
    item_nxt.flags.use_a4 = (order_r >= 3'd4);
  end

  pnf_fifo #(
    .W     ($bits(pnf_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_issue_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (item_nxt),
    .pop   (q_pop),
    .full  (full),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  assign q_item = pnf_pkg::item_t'(q_rdata);

endmodule
`default_nettype wire

>>> rtl/core/pnf_back.sv
// Back end: root chain, reciprocal, power series, term sum and final scaling divide.
`default_nettype none
module pnf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               q_empty,
  input  pnf_pkg::item_t     q_item,
  output logic               q_pop,
  input  pnf_pkg::coef_t     cfg,
  output logic               res_valid,
  output pnf_pkg::result_t   res
);

  localparam int unsigned FW = $bits(pnf_pkg::flags_t);

  // Take a request whenever the pipeline moves
  assign q_pop = en;

  // theta = td^(1/8) by three square roots
  logic          v1, v2, v3;
  logic [31:0]   s1, s2, th;
  logic [FW-1:0] f1, f2, f3;

  pnf_isqrt #(.SB_W(FW)) u_sqrt1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(~q_empty), .in_rad({q_item.td, 16'h0000}), .in_sb(q_item.flags),
    .out_valid(v1), .out_root(s1), .out_sb(f1)
  );

  pnf_isqrt #(.SB_W(FW)) u_sqrt2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v1), .in_rad({s1, 32'h0000_0000}), .in_sb(f1),
    .out_valid(v2), .out_root(s2), .out_sb(f2)
  );

  pnf_isqrt #(.SB_W(FW)) u_sqrt3 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v2), .in_rad({s2, 32'h0000_0000}), .in_sb(f2),
    .out_valid(v3), .out_root(th), .out_sb(f3)
  );

  // u = 2^60 / theta
  logic          vu;
  logic [34:0]   u;
  logic [FW-1:0] fu;

  pnf_div #(.QW(35), .DW(32), .SB_W(FW)) u_recip (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v3), .in_rem(32'h0200_0000), .in_low(35'd0), .in_den(th), .in_sb(f3),
    .out_valid(vu), .out_quo(u), .out_sb(fu)
  );

  // Powers of u
  logic          vm1;
  logic [36:0]   u2;
  logic [FW-1:0] f_m1;
  logic [34:0]   u_m1;

  pnf_mul #(.AW(35), .BW(35), .OW(37), .SH(32), .SB_W(FW+35)) u_mul_u2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vu), .in_a(u), .in_b(u), .in_sb({fu, u}),
    .out_valid(vm1), .out_p(u2), .out_sb({f_m1, u_m1})
  );

  logic          vm2;
  logic [38:0]   u3;
  logic [40:0]   u4;
  logic [FW-1:0] f_m2;
  logic [34:0]   u_m2;
  logic [36:0]   u2_m2;

  pnf_mul #(.AW(37), .BW(35), .OW(39), .SH(32), .SB_W(FW+35+37)) u_mul_u3 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vm1), .in_a(u2), .in_b(u_m1), .in_sb({f_m1, u_m1, u2}),
    .out_valid(vm2), .out_p(u3), .out_sb({f_m2, u_m2, u2_m2})
  );

  pnf_mul #(.AW(37), .BW(37), .OW(41), .SH(32), .SB_W(1)) u_mul_u4 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vm1), .in_a(u2), .in_b(u2), .in_sb(1'b0),
    .out_valid(), .out_p(u4), .out_sb()
  );

  logic          vm3;
  logic [42:0]   u5;
  logic [44:0]   u6;
  logic [FW-1:0] f_m3;
  logic [34:0]   u_m3;
  logic [38:0]   u3_m3;

  pnf_mul #(.AW(41), .BW(35), .OW(43), .SH(32), .SB_W(FW+35+39)) u_mul_u5 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vm2), .in_a(u4), .in_b(u_m2), .in_sb({f_m2, u_m2, u3}),
    .out_valid(vm3), .out_p(u5), .out_sb({f_m3, u_m3, u3_m3})
  );

  pnf_mul #(.AW(41), .BW(37), .OW(45), .SH(32), .SB_W(1)) u_mul_u6 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vm2), .in_a(u4), .in_b(u2_m2), .in_sb(1'b0),
    .out_valid(), .out_p(u6), .out_sb()
  );

  // Coefficient magnitudes and signs
  logic [31:0] mag2, mag3, mag4;

  assign mag2 = cfg.a2[31] ? (~cfg.a2 + 32'd1) : cfg.a2;
  assign mag3 = cfg.a3[31] ? (~cfg.a3 + 32'd1) : cfg.a3;
  assign mag4 = cfg.a4[31] ? (~cfg.a4 + 32'd1) : cfg.a4;

  logic          vm4;
  logic [46:0]   u7;
  logic [49:0]   t5m;
  logic [51:0]   t6m;
  logic [FW-1:0] f_m4;
  logic [38:0]   u3_m4;

  pnf_mul #(.AW(45), .BW(35), .OW(47), .SH(32), .SB_W(FW+39)) u_mul_u7 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vm3), .in_a(u6), .in_b(u_m3), .in_sb({f_m3, u3_m3}),
    .out_valid(vm4), .out_p(u7), .out_sb({f_m4, u3_m4})
  );

  pnf_mul #(.AW(32), .BW(43), .OW(50), .SH(24), .SB_W(1)) u_mul_t5 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vm3), .in_a(mag2), .in_b(u5), .in_sb(1'b0),
    .out_valid(), .out_p(t5m), .out_sb()
  );

  pnf_mul #(.AW(32), .BW(45), .OW(52), .SH(24), .SB_W(1)) u_mul_t6 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vm3), .in_a(mag3), .in_b(u6), .in_sb(1'b0),
    .out_valid(), .out_p(t6m), .out_sb()
  );

  logic          vm5;
  logic [53:0]   t7m;
  logic [FW-1:0] f_m5;
  logic [38:0]   u3_m5;
  logic [49:0]   t5_m5;
  logic [51:0]   t6_m5;

  pnf_mul #(.AW(32), .BW(47), .OW(54), .SH(24), .SB_W(FW+39+50+52)) u_mul_t7 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vm4), .in_a(mag4), .in_b(u7), .in_sb({f_m4, u3_m4, t5m, t6m}),
    .out_valid(vm5), .out_p(t7m), .out_sb({f_m5, u3_m5, t5_m5, t6_m5})
  );

  // Sum the terms that the order keeps
  pnf_pkg::flags_t fl5;
  logic [57:0]     term5, term6, term7, sum_nxt;
  logic [57:0]     sum_r;
  logic            sum_v_r;
  logic            sum_bad_r;

  assign fl5 = pnf_pkg::flags_t'(f_m5);

  always_comb begin
    term5   = cfg.a2[31] ? (58'd0 - 58'(t5_m5)) : 58'(t5_m5);
    term6   = cfg.a3[31] ? (58'd0 - 58'(t6_m5)) : 58'(t6_m5);
    term7   = cfg.a4[31] ? (58'd0 - 58'(t7m))   : 58'(t7m);
    sum_nxt = 58'(u3_m5)
            + (fl5.use_a2 ? term5 : 58'd0)
            - (fl5.use_a3 ? term6 : 58'd0)
            + (fl5.use_a4 ? term7 : 58'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
    end else if (en) begin
      sum_v_r <= vm5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r     <= sum_nxt;
      sum_bad_r <= fl5.bad;
    end
  end

  // Classify the sum: zero output, saturation or a real divide
  logic        pos;
  logic        big;
  logic        force_zero;
  logic        force_max;
  logic        vd;
  logic [51:0] quo;
  logic [2:0]  fd;

  assign pos        = ~sum_r[57] & (sum_r != 58'd0);
  assign big        = ({3'b000, sum_r[56:0]} >= {cfg.mass, 28'h000_0000});
  assign force_zero = sum_bad_r | ~pos;
  assign force_max  = ~force_zero & ((cfg.mass == 32'd0) | big);

  pnf_div #(.QW(52), .DW(32), .SB_W(3)) u_scale (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sum_v_r), .in_rem({2'b00, sum_r[57:28]}),
    .in_low({sum_r[27:0], 24'h00_0000}), .in_den(cfg.mass),
    .in_sb({sum_bad_r, force_zero, force_max}),
    .out_valid(vd), .out_quo(quo), .out_sb(fd)
  );

  // Select the final frequency
  assign res_valid = vd;
  assign res.bad   = fd[2];
  assign res.freq  = fd[1] ? '0 : (fd[0] ? pnf_pkg::FREQ_MAX : quo);

endmodule
`default_nettype wire

>>> rtl/core/pn_inspiral_frequency_of_time.sv
// Top level of the post-Newtonian inspiral frequency block.
//
// Usage:
//   Input queue: drive in_time_to_merge (td, Q32.16) and raise push; a request
//   is taken at a rising edge with push high and full low. Result queue: while
//   empty is low, out_wave_frequency (Q20.32) and out_bad_time show the oldest
//   result; raising pop takes it. Results leave in request order.
//   Configuration: cfg_we with cfg_index and cfg_wdata writes one register;
//   write only while no request is in flight.
//   Throughput: one request per cycle while the result queue has room. Every stage
//   does one step: the three 32-step square roots, the 35-step reciprocal divider
//   and the 52-step scaling divider each advance one bit per cycle, and the
//   products pass through split multipliers.
//   Stall: when the result queue is full the whole back pipeline holds; the
//   issue queue then fills and full rises.
//   Reset: synchronous, active low; queues and pipeline empty, registers take
//   order 4, zero coefficients and a unit mass divisor.
`default_nettype none
module pn_inspiral_frequency_of_time #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [pnf_pkg::TD_W-1:0]   in_time_to_merge,
  output logic                       empty,
  input  logic                       pop,
  output logic [pnf_pkg::FREQ_W-1:0] out_wave_frequency,
  output logic                       out_bad_time,
  input  logic                       cfg_we,
  input  logic [pnf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pnf_pkg::CFG_W-1:0]  cfg_wdata
);

  logic             q_pop;
  logic             q_empty;
  pnf_pkg::item_t   q_item;
  pnf_pkg::coef_t   cfg;
  logic             en;
  logic             res_valid;
  pnf_pkg::result_t res;
  logic             ofifo_full;
  logic [$bits(pnf_pkg::result_t)-1:0] ofifo_rdata;
  pnf_pkg::result_t out_res;

  pnf_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .td        (in_time_to_merge),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_pop     (q_pop),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .cfg       (cfg)
  );

  // Advance the back pipeline while the result queue has room
  assign en = ~ofifo_full;

  pnf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  pnf_fifo #(
    .W     ($bits(pnf_pkg::result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid & en),
    .wdata (res),
    .pop   (pop),
    .full  (ofifo_full),
    .empty (empty),
    .rdata (ofifo_rdata)
  );

  assign out_res            = pnf_pkg::result_t'(ofifo_rdata);
  assign out_wave_frequency = out_res.freq;
  assign out_bad_time       = out_res.bad;

endmodule
`default_nettype wire
